// ===== sv/msp_pkg.sv =====
// Shared types, constants and a helper function of the 2x2 Smith predictor block.
package msp_pkg;

	localparam int MAX_DELAY_DEF    = 256;
	localparam int SIGNAL_WIDTH_DEF = 32;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAINS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHAS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAYS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DECOUPLE   = 3'd7;
	localparam int CFG_DATA_W = 64;

	localparam logic [15:0] ALPHA_ONE = 16'd32768;

	// Divider sizes: the decoupler numerator is a 49-bit difference scaled by 256,
	// plus half the divisor for rounding.
	localparam int DIV_NW = 58;
	localparam int DIV_DW = 33;
	localparam int DIV_CW = $clog2(DIV_NW);

	typedef struct packed {
		logic signed [31:0] setpoint_one;
		logic signed [31:0] setpoint_two;
		logic signed [31:0] measured_one;
		logic signed [31:0] measured_two;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] drive_one;
		logic signed [31:0] drive_two;
		logic               decoupler_bypassed;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TGT_MUL,
		ST_TGT,
		ST_STEP_MUL,
		ST_STEP,
		ST_LINE,
		ST_LINE_RD,
		ST_ERR,
		ST_P_MUL,
		ST_P,
		ST_I_MUL,
		ST_I,
		ST_LIM,
		ST_DET_A,
		ST_DET_B,
		ST_DET_C,
		ST_NUM_A,
		ST_NUM_B,
		ST_NUM_C,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	// Saturate to a signed value of w bits, returned sign-extended to 32 bits.
	function automatic logic signed [31:0] sat_sig(input logic signed [71:0] x,
			input int unsigned w);
		logic signed [71:0] hi;
		logic signed [71:0] lo;
		hi = (72'sd1 <<< (w - 1)) - 72'sd1;
		lo = -hi - 72'sd1;
		if (x > hi)
			return hi[31:0];
		else if (x < lo)
			return lo[31:0];
		else
			return x[31:0];
	endfunction

endpackage

// ===== sv/msp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/msp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module msp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [msp_pkg::DIV_NW-1:0]    dividend,
	input  logic [msp_pkg::DIV_DW-1:0]    divisor,
	output logic                          busy,
	output logic                          done,
	output logic [msp_pkg::DIV_NW-1:0]    quotient
);

	logic                         busy_q;
	logic                         done_q;
	logic [msp_pkg::DIV_CW-1:0]   cnt_q;
	logic [msp_pkg::DIV_NW-1:0]   quo_q;
	logic [msp_pkg::DIV_DW-1:0]   rem_q;
	logic [msp_pkg::DIV_DW-1:0]   dvs_q;
	logic [msp_pkg::DIV_DW:0]     rem_sh;
	logic                         ge;

	assign rem_sh = {rem_q, quo_q[msp_pkg::DIV_NW-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= msp_pkg::DIV_CW'(msp_pkg::DIV_NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[msp_pkg::DIV_NW-2:0], ge};
			rem_q <= ge ? msp_pkg::DIV_DW'(rem_sh - {1'b0, dvs_q})
			            : rem_sh[msp_pkg::DIV_DW-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/mimo_smith_predictor_pi_2x2_top.sv =====
// Top level of the 2x2 Smith predictor with PI loops and static decoupler.
//
//  Channel  Signals                         Transfer when
//  in       in_valid, in_ready, in_data     in_valid && in_ready
//  out      out_valid, out_ready, out_data  out_valid && out_ready
//  cfg      cfg_we, cfg_index, cfg_data     cfg_we
//
// A sample takes longest with the decoupler on and the gains regular, since
// two 58-step divisions then run; with the decoupler off, or on with the
// gains singular, they are skipped. One shared 33x33 multiplier carries
// all other products, one per cycle.
// After reset all 4*MAX_DELAY words of the dead-time memory are cleared before
// the first sample is taken. A finished result waits in the output register;
// the next sample is taken meanwhile but cannot finish until it is free.
module mimo_smith_predictor_pi_2x2_top #(
	parameter int MAX_DELAY    = msp_pkg::MAX_DELAY_DEF,
	parameter int SIGNAL_WIDTH = msp_pkg::SIGNAL_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  msp_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output msp_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [msp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SIG_EFF = (SIGNAL_WIDTH < 32) ? SIGNAL_WIDTH : 32;
	localparam int DEPTH   = 4 * MAX_DELAY;
	localparam int AW      = $clog2(DEPTH);
	localparam int PW      = $clog2(MAX_DELAY);

	msp_pkg::state_t state_q, state_d;

	// Configuration
	logic [63:0] gains_q, alphas_q, prop_q, integ_cfg_q, lower_q, upper_q;
	logic [31:0] delays_q;
	logic        dec_en_q;

	// Datapath state
	logic signed [31:0] model_q [4];
	logic signed [31:0] ym_q [4];
	logic signed [31:0] integ_q [2];
	logic signed [31:0] prev_q [2];
	logic signed [31:0] uc_q [2];
	logic signed [31:0] dq_q [2];
	logic signed [32:0] diff_q;
	logic signed [31:0] err_q;
	logic signed [31:0] pt_q;
	logic signed [65:0] prod_q;
	logic signed [65:0] acc_q;
	logic signed [32:0] det_q;
	logic signed [57:0] num_q;
	logic               neg_q;
	logic               bypass_q;
	logic [1:0]         ch_q;
	logic               lp_q;
	logic               sel_q;
	logic [PW-1:0]      wp_q;
	logic [AW-1:0]      clr_q;
	msp_pkg::in_item_t  in_q;
	logic               out_valid_q;
	msp_pkg::out_item_t out_q;

	// Shared multiplier operands
	logic signed [32:0] mul_a, mul_b;

	// RAM and divider
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;
	logic                        div_start;
	logic                        div_done;
	logic                        div_busy;
	logic [msp_pkg::DIV_NW-1:0]  div_dividend, div_quo;
	logic [msp_pkg::DIV_DW-1:0]  div_divisor;

	logic in_fire, out_free;

	// Per-channel fields
	logic signed [15:0] k_ch [4];
	logic [15:0]        a_ch [4];
	logic [PW-1:0]      off_ch;
	logic [12:0]        d_ext, d_lim, p_ext;
	logic [AW-1:0]      base;

	// Combinational results
	logic signed [31:0] target, model_new, err_new, pt_new, integ_new;
	logic signed [31:0] lim_u, lim_integ;
	logic signed [32:0] u_sum, u1;
	logic signed [71:0] sp_w, pv_w, yp_w, ys_w;
	logic signed [32:0] det_new;
	logic [57:0]        num_abs;
	logic [32:0]        det_abs;
	logic signed [71:0] quo_s;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			k_ch[c] = $signed(gains_q[16*c +: 16]);
			a_ch[c] = (alphas_q[16*c +: 16] > msp_pkg::ALPHA_ONE) ? msp_pkg::ALPHA_ONE
			          : alphas_q[16*c +: 16];
		end
	end

	// Dead-time read offset, with the delay capped at MAX_DELAY-1.
	always_comb begin
		d_ext = 13'(delays_q[8*ch_q +: 8]);
		d_lim = (d_ext > 13'(MAX_DELAY - 1)) ? 13'(MAX_DELAY - 1) : d_ext;
		p_ext = 13'(wp_q);
		off_ch = (p_ext >= d_lim) ? PW'(p_ext - d_lim)
		                          : PW'(p_ext + 13'(MAX_DELAY) - d_lim);
		base = AW'(ch_q) * AW'(MAX_DELAY);
	end

	// Arithmetic on the registered product and on the other registered state.
	always_comb begin
		target    = msp_pkg::sat_sig(72'((prod_q + 66'sd128) >>> 8), SIG_EFF);
		model_new = msp_pkg::sat_sig(72'(model_q[ch_q])
		                             + 72'((prod_q + 66'sd16384) >>> 15), SIG_EFF);
		sp_w = 72'(msp_pkg::sat_sig(72'(lp_q ? in_q.setpoint_two : in_q.setpoint_one),
		                            SIG_EFF));
		pv_w = 72'(msp_pkg::sat_sig(72'(lp_q ? in_q.measured_two : in_q.measured_one),
		                            SIG_EFF));
		yp_w = 72'(model_q[{lp_q, 1'b0}]) + 72'(model_q[{lp_q, 1'b1}]);
		ys_w = 72'(ym_q[{lp_q, 1'b0}]) + 72'(ym_q[{lp_q, 1'b1}]);
		err_new = msp_pkg::sat_sig(sp_w - (yp_w + pv_w - ys_w), SIG_EFF);
		pt_new = msp_pkg::sat_sig(72'((prod_q + 66'sd32768) >>> 16), SIG_EFF);
		integ_new = msp_pkg::sat_sig(72'(integ_q[lp_q])
		                             + 72'((prod_q + 66'sd32768) >>> 16), SIG_EFF);
		// Upper limit first, then the lower one, so the lower limit wins.
		u_sum = 33'(pt_q) + 33'(integ_q[lp_q]);
		u1 = u_sum;
		lim_integ = integ_q[lp_q];
		if (u1 > 33'($signed(upper_q[32*lp_q +: 32]))) begin
			u1 = 33'($signed(upper_q[32*lp_q +: 32]));
			lim_integ = msp_pkg::sat_sig(72'(u1) - 72'(pt_q), SIG_EFF);
		end
		if (u1 < 33'($signed(lower_q[32*lp_q +: 32]))) begin
			u1 = 33'($signed(lower_q[32*lp_q +: 32]));
			lim_integ = msp_pkg::sat_sig(72'(u1) - 72'(pt_q), SIG_EFF);
		end
		lim_u = msp_pkg::sat_sig(72'(u1), SIG_EFF);
		det_new = 33'(acc_q - prod_q);
		num_abs = num_q[57] ? 58'(-num_q) : 58'(num_q);
		det_abs = det_q[32] ? 33'(-det_q) : 33'(det_q);
		quo_s = neg_q ? -72'(div_quo) : 72'(div_quo);
	end

	assign div_dividend = num_abs + 58'(det_abs >> 1);
	assign div_divisor  = det_abs;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			msp_pkg::ST_CLEAR:    if (clr_q == AW'(DEPTH - 1)) state_d = msp_pkg::ST_IDLE;
			msp_pkg::ST_IDLE:     if (in_fire) state_d = msp_pkg::ST_TGT_MUL;
			msp_pkg::ST_TGT_MUL:  state_d = msp_pkg::ST_TGT;
			msp_pkg::ST_TGT:      state_d = msp_pkg::ST_STEP_MUL;
			msp_pkg::ST_STEP_MUL: state_d = msp_pkg::ST_STEP;
			msp_pkg::ST_STEP:     state_d = msp_pkg::ST_LINE;
			msp_pkg::ST_LINE:     state_d = msp_pkg::ST_LINE_RD;
			msp_pkg::ST_LINE_RD:  state_d = (ch_q == 2'd3) ? msp_pkg::ST_ERR
			                                               : msp_pkg::ST_TGT_MUL;
			msp_pkg::ST_ERR:      state_d = msp_pkg::ST_P_MUL;
			msp_pkg::ST_P_MUL:    state_d = msp_pkg::ST_P;
			msp_pkg::ST_P:        state_d = msp_pkg::ST_I_MUL;
			msp_pkg::ST_I_MUL:    state_d = msp_pkg::ST_I;
			msp_pkg::ST_I:        state_d = msp_pkg::ST_LIM;
			msp_pkg::ST_LIM: begin
				if (!lp_q)
					state_d = msp_pkg::ST_ERR;
				else if (dec_en_q)
					state_d = msp_pkg::ST_DET_A;
				else
					state_d = msp_pkg::ST_FINISH;
			end
			msp_pkg::ST_DET_A:    state_d = msp_pkg::ST_DET_B;
			msp_pkg::ST_DET_B:    state_d = msp_pkg::ST_DET_C;
			msp_pkg::ST_DET_C:    state_d = (det_new == '0) ? msp_pkg::ST_FINISH
			                                                : msp_pkg::ST_NUM_A;
			msp_pkg::ST_NUM_A:    state_d = msp_pkg::ST_NUM_B;
			msp_pkg::ST_NUM_B:    state_d = msp_pkg::ST_NUM_C;
			msp_pkg::ST_NUM_C:    state_d = msp_pkg::ST_DIV_START;
			msp_pkg::ST_DIV_START: state_d = msp_pkg::ST_DIV_WAIT;
			msp_pkg::ST_DIV_WAIT: begin
				if (div_done)
					state_d = sel_q ? msp_pkg::ST_FINISH : msp_pkg::ST_NUM_A;
			end
			msp_pkg::ST_FINISH:   if (out_free) state_d = msp_pkg::ST_IDLE;
			default:              state_d = msp_pkg::ST_IDLE;
		endcase
	end

	// Control outputs: multiplier operands, memory port, divider start, input ready.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		ram_we = 1'b0;
		ram_waddr = base + AW'(wp_q);
		ram_wdata = model_q[ch_q];
		ram_raddr = base + AW'(off_ch);
		div_start = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			msp_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			msp_pkg::ST_IDLE: in_ready = 1'b1;
			msp_pkg::ST_TGT_MUL: begin
				mul_a = 33'(k_ch[ch_q]);
				mul_b = 33'(prev_q[ch_q[0]]);
			end
			msp_pkg::ST_STEP_MUL: begin
				mul_a = $signed({17'd0, a_ch[ch_q]});
				mul_b = diff_q;
			end
			msp_pkg::ST_LINE: ram_we = 1'b1;
			msp_pkg::ST_P_MUL: begin
				mul_a = 33'($signed(prop_q[32*lp_q +: 32]));
				mul_b = 33'(err_q);
			end
			msp_pkg::ST_I_MUL: begin
				mul_a = 33'($signed(integ_cfg_q[32*lp_q +: 32]));
				mul_b = 33'(err_q);
			end
			msp_pkg::ST_DET_A: begin
				mul_a = 33'(k_ch[0]);
				mul_b = 33'(k_ch[3]);
			end
			msp_pkg::ST_DET_B: begin
				mul_a = 33'(k_ch[1]);
				mul_b = 33'(k_ch[2]);
			end
			msp_pkg::ST_NUM_A: begin
				mul_a = sel_q ? 33'(k_ch[0]) : 33'(k_ch[3]);
				mul_b = sel_q ? 33'(uc_q[1]) : 33'(uc_q[0]);
			end
			msp_pkg::ST_NUM_B: begin
				mul_a = sel_q ? 33'(k_ch[2]) : 33'(k_ch[1]);
				mul_b = sel_q ? 33'(uc_q[0]) : 33'(uc_q[1]);
			end
			msp_pkg::ST_DIV_START: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
			alphas_q <= '0;
			delays_q <= '0;
			prop_q <= '0;
			integ_cfg_q <= '0;
			lower_q <= '0;
			upper_q <= '0;
			dec_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				msp_pkg::CFG_GAINS:    gains_q <= cfg_data;
				msp_pkg::CFG_ALPHAS:   alphas_q <= cfg_data;
				msp_pkg::CFG_DELAYS:   delays_q <= cfg_data[31:0];
				msp_pkg::CFG_PROP:     prop_q <= cfg_data;
				msp_pkg::CFG_INTEG:    integ_cfg_q <= cfg_data;
				msp_pkg::CFG_LOWER:    lower_q <= cfg_data;
				msp_pkg::CFG_UPPER:    upper_q <= cfg_data;
				msp_pkg::CFG_DECOUPLE: dec_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer-controlled state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) model_q[c] <= '0;
			for (int l = 0; l < 2; l++) begin
				integ_q[l] <= '0;
				prev_q[l] <= '0;
			end
			wp_q <= '0;
			clr_q <= '0;
			ch_q <= '0;
			lp_q <= 1'b0;
			sel_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == msp_pkg::ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				msp_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				msp_pkg::ST_IDLE: begin
					if (in_fire) begin
						wp_q <= (wp_q == PW'(MAX_DELAY - 1)) ? '0 : wp_q + 1'b1;
						ch_q <= '0;
						lp_q <= 1'b0;
						sel_q <= 1'b0;
					end
				end
				msp_pkg::ST_STEP: model_q[ch_q] <= model_new;
				msp_pkg::ST_LINE_RD: ch_q <= ch_q + 1'b1;
				msp_pkg::ST_I: integ_q[lp_q] <= integ_new;
				msp_pkg::ST_LIM: begin
					integ_q[lp_q] <= lim_integ;
					lp_q <= 1'b1;
				end
				msp_pkg::ST_DIV_WAIT: if (div_done) sel_q <= 1'b1;
				msp_pkg::ST_FINISH: begin
					if (out_free) begin
						prev_q[0] <= dq_q[0];
						prev_q[1] <= dq_q[1];
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			msp_pkg::ST_IDLE: begin
				if (in_fire) begin
					in_q <= in_data;
					bypass_q <= 1'b0;
				end
			end
			msp_pkg::ST_TGT: diff_q <= 33'(target) - 33'(model_q[ch_q]);
			// A zero dead time reads the value just written.
			msp_pkg::ST_LINE_RD: ym_q[ch_q] <= (d_lim == '0) ? model_q[ch_q]
			                                                 : $signed(ram_rdata);
			msp_pkg::ST_ERR: err_q <= err_new;
			msp_pkg::ST_P: pt_q <= pt_new;
			msp_pkg::ST_LIM: begin
				uc_q[lp_q] <= lim_u;
				dq_q[lp_q] <= lim_u;
			end
			msp_pkg::ST_DET_B: acc_q <= prod_q;
			msp_pkg::ST_DET_C: begin
				det_q <= det_new;
				if (det_new == '0)
					bypass_q <= 1'b1;
			end
			msp_pkg::ST_NUM_B: acc_q <= prod_q;
			msp_pkg::ST_NUM_C: begin
				num_q <= 58'(acc_q - prod_q) <<< 8;
				neg_q <= ((acc_q - prod_q) < 0) != det_q[32];
			end
			msp_pkg::ST_DIV_WAIT: begin
				if (div_done)
					dq_q[sel_q] <= msp_pkg::sat_sig(quo_s, SIG_EFF);
			end
			msp_pkg::ST_FINISH: begin
				if (out_free) begin
					out_q.drive_one <= dq_q[0];
					out_q.drive_two <= dq_q[1];
					out_q.decoupler_bypassed <= bypass_q;
				end
			end
			default: ;
		endcase
		prod_q <= mul_a * mul_b;
	end

	msp_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	msp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A sample in progress blocks the input until it has been handed over.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input taken again while a sample is in progress");

	a_bypass_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msp_pkg::ST_FINISH && bypass_q) |-> dec_en_q)
		else $error("decoupler bypass reported with decoupling off");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msp_pkg::ST_CLEAR) |-> (!in_ready && !out_valid_q))
		else $error("activity during the memory clearing pass");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the 2x2 Smith predictor with PI loops and decoupler.
`timescale 1ns / 100ps

class drive_scoreboard;
	// Predictor state
	longint model_y[4];
	longint line_mem[4][256];
	int unsigned wr_ptr;
	longint integ[2];
	longint prev_u[2];
	logic [63:0] gains, alphas, props, integs, lowers, uppers;
	logic [31:0] delays;
	logic decouple;
	msp_pkg::out_item_t pending_drives[$];
	int mismatches;

	function new();
		gains = 0; alphas = 0; props = 0; integs = 0; lowers = 0; uppers = 0;
		delays = 0; decouple = 0; wr_ptr = 0; mismatches = 0;
		foreach (model_y[i]) model_y[i] = 0;
		foreach (line_mem[c, j]) line_mem[c][j] = 0;
		integ[0] = 0; integ[1] = 0; prev_u[0] = 0; prev_u[1] = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [63:0] v);
		case (idx)
		msp_pkg::CFG_GAINS: gains = v;
		msp_pkg::CFG_ALPHAS: alphas = v;
		msp_pkg::CFG_DELAYS: delays = v[31:0];
		msp_pkg::CFG_PROP: props = v;
		msp_pkg::CFG_INTEG: integs = v;
		msp_pkg::CFG_LOWER: lowers = v;
		msp_pkg::CFG_UPPER: uppers = v;
		msp_pkg::CFG_DECOUPLE: decouple = v[0];
		default: ;
		endcase
	endfunction

	function longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Round to nearest, ties upward; >>> on longint is a floor shift.
	function longint round_shift(longint x, int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function longint round_div(longint num, longint den);
		longint an, ad, q;
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = (an + ad / 2) / ad;
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function void note_sample(msp_pkg::in_item_t s);
		longint k[4], ym[4], uc[2], tgt, a, d0, d1, det;
		longint sp, pv, err, kp, ki, lo, hi, pt, u;
		int unsigned d;
		msp_pkg::out_item_t r;
		r = '0;
		for (int ch = 0; ch < 4; ch++) begin
			a = longint'(alphas[16*ch +: 16]);
			if (a > 32768) a = 32768;
			k[ch] = $signed(gains[16*ch +: 16]);
			tgt = clamp32(round_shift(k[ch] * prev_u[ch & 1], 8));
			model_y[ch] = clamp32(model_y[ch] + round_shift(a * (tgt - model_y[ch]), 15));
		end
		wr_ptr = (wr_ptr + 1) % 256;
		for (int ch = 0; ch < 4; ch++) begin
			d = 32'(delays[8*ch +: 8]);
			line_mem[ch][wr_ptr] = model_y[ch];
			ym[ch] = line_mem[ch][(wr_ptr + 256 - d) % 256];
		end
		for (int i = 0; i < 2; i++) begin
			sp = (i == 0) ? longint'(s.setpoint_one) : longint'(s.setpoint_two);
			pv = (i == 0) ? longint'(s.measured_one) : longint'(s.measured_two);
			err = clamp32(sp - (model_y[2*i] + model_y[2*i+1] + pv - ym[2*i] - ym[2*i+1]));
			kp = $signed(props[32*i +: 32]);
			ki = $signed(integs[32*i +: 32]);
			lo = $signed(lowers[32*i +: 32]);
			hi = $signed(uppers[32*i +: 32]);
			pt = clamp32(round_shift(kp * err, 16));
			integ[i] = clamp32(integ[i] + round_shift(ki * err, 16));
			u = pt + integ[i];
			if (u > hi) begin
				u = hi;
				integ[i] = clamp32(hi - pt);
			end
			if (u < lo) begin
				u = lo;
				integ[i] = clamp32(lo - pt);
			end
			uc[i] = clamp32(u);
		end
		d0 = uc[0];
		d1 = uc[1];
		if (decouple) begin
			det = k[0] * k[3] - k[1] * k[2];
			if (det == 0) begin
				r.decoupler_bypassed = 1'b1;
			end else begin
				d0 = clamp32(round_div((k[3] * uc[0] - k[1] * uc[1]) * 256, det));
				d1 = clamp32(round_div((k[0] * uc[1] - k[2] * uc[0]) * 256, det));
			end
		end
		prev_u[0] = d0;
		prev_u[1] = d1;
		r.drive_one = d0[31:0];
		r.drive_two = d1[31:0];
		pending_drives.push_back(r);
	endfunction

	function void check_drive(msp_pkg::out_item_t got);
		msp_pkg::out_item_t want;
		if (pending_drives.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h", got);
			return;
		end
		want = pending_drives.pop_front();
		if (got.drive_one !== want.drive_one || got.drive_two !== want.drive_two ||
				got.decoupler_bypassed !== want.decoupler_bypassed) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected %0d %0d %b, got %0d %0d %b",
					want.drive_one, want.drive_two, want.decoupler_bypassed,
					got.drive_one, got.drive_two, got.decoupler_bypassed);
		end
	endfunction
endclass

module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	msp_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	msp_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [msp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [msp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	drive_scoreboard board = new();
	int unsigned quiet_cycles = 0;

	mimo_smith_predictor_pi_2x2_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a cycle with no transfer on either channel counts towards the limit.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_drive(out_data);

	// Receiver: random stall before each result, with calm stretches.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		board.write_reg(idx, v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(msp_pkg::in_item_t s, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (!in_ready);
		board.note_sample(s);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_drives.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_sig();
		case ($urandom_range(0, 5))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return $urandom;
		default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	function automatic msp_pkg::in_item_t rand_sample();
		msp_pkg::in_item_t s;
		s.setpoint_one = rand_sig();
		s.setpoint_two = rand_sig();
		s.measured_one = rand_sig();
		s.measured_two = rand_sig();
		return s;
	endfunction

	function automatic logic [15:0] rand_gain();
		case ($urandom_range(0, 4))
		0: return 16'h7FFF;
		1: return 16'h8000;
		2: return 16'h0000;
		default: return 16'($urandom_range(0, 16'h0400) - 16'h0200);
		endcase
	endfunction

	// One random setting of all registers; mode 1 reworks the gains, mode 2 picks extreme PI gains and loop-two limits.
	task automatic random_setting(int mode);
		logic [63:0] g, al, pr, ig, lo, hi;
		logic [31:0] lo1, hi1, lo2, hi2;
		g = {rand_gain(), rand_gain(), rand_gain(), rand_gain()};
		if (mode == 1)
			g = {g[15:0], g[31:16], 16'(g[47:32] << 1), 16'(g[63:48] << 1)};
		for (int c = 0; c < 4; c++)
			al[16*c +: 16] = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 32768));
		pr = (mode == 2) ? {$urandom, $urandom} :
			{32'($urandom_range(0, 32'h0003_0000)), 32'($urandom_range(0, 32'h0003_0000))};
		ig = (mode == 2) ? {$urandom, $urandom} :
			{32'($urandom_range(0, 32'h0000_8000)), 32'($urandom_range(0, 32'h0000_8000))};
		lo1 = -$urandom_range(0, 32'h0100_0000);
		hi1 = $urandom_range(0, 32'h0100_0000);
		lo2 = (mode == 2) ? $urandom : -$urandom_range(0, 32'h0100_0000);
		hi2 = (mode == 2) ? $urandom : $urandom_range(0, 32'h0100_0000);
		write_reg(msp_pkg::CFG_GAINS, g);
		write_reg(msp_pkg::CFG_ALPHAS, al);
		write_reg(msp_pkg::CFG_DELAYS, 64'($urandom));
		write_reg(msp_pkg::CFG_PROP, pr);
		write_reg(msp_pkg::CFG_INTEG, ig);
		write_reg(msp_pkg::CFG_LOWER, {lo2, lo1});
		write_reg(msp_pkg::CFG_UPPER, {hi2, hi1});
		write_reg(msp_pkg::CFG_DECOUPLE, 64'($urandom_range(0, 1)));
	endtask

	initial begin
		msp_pkg::in_item_t s;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity-like plant, alphas from zero to over one, zero and full
		// delays, crossed limits, then singular gains with the decoupler on.
		write_reg(msp_pkg::CFG_GAINS, {16'h0100, 16'h0080, 16'h0040, 16'h0100});
		write_reg(msp_pkg::CFG_ALPHAS, {16'hFFFF, 16'h8000, 16'h0000, 16'h4000});
		write_reg(msp_pkg::CFG_DELAYS, 64'({8'hFF, 8'd0, 8'd3, 8'd1}));
		write_reg(msp_pkg::CFG_PROP, {32'h0001_0000, 32'h0002_0000});
		write_reg(msp_pkg::CFG_INTEG, {32'h0000_0000, 32'h0000_1000});
		write_reg(msp_pkg::CFG_LOWER, {32'h0010_0000, 32'hFFF0_0000});
		write_reg(msp_pkg::CFG_UPPER, {32'hFFF0_0000, 32'h0010_0000});
		write_reg(msp_pkg::CFG_DECOUPLE, 64'd1);
		s = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
		send_sample(s, 0);
		s = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
		send_sample(s, 0);
		for (int i = 0; i < 8; i++) send_sample(rand_sample(), i[0]);
		drain();
		write_reg(msp_pkg::CFG_GAINS, {16'h0200, 16'h0100, 16'h0100, 16'h0080});
		write_reg(msp_pkg::CFG_LOWER, {32'h8000_0000, 32'h8000_0000});
		write_reg(msp_pkg::CFG_UPPER, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
		write_reg(msp_pkg::CFG_INTEG, {32'h7FFF_FFFF, 32'h8000_0000});
		for (int i = 0; i < 6; i++) send_sample(rand_sample(), 0);
		drain();
		write_reg(msp_pkg::CFG_DECOUPLE, 64'd0);
		write_reg(msp_pkg::CFG_GAINS, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(msp_pkg::CFG_ALPHAS, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < 6; i++) send_sample(rand_sample(), 0);
		drain();

		// Random phases with a new setting each; each drain is a pause
		// until every expected result has come.
		for (int ph = 0; ph < 24; ph++) begin
			random_setting(ph % 3);
			for (int i = 0; i < 80; i++) send_sample(rand_sample(), $urandom_range(0, 4) == 0);
			drain();
		end
		if (board.mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
